@@ hdl/khs_pkg.sv @@
// khs_pkg: shared types, constants and helpers for the key hash server select block
// no dependencies; imported by every module of the block
package khs_pkg;

    localparam int unsigned SUM_W       = 16;
    localparam int unsigned HASH_W      = 32;
    localparam int unsigned CNT_W       = 9;
    localparam int unsigned IDX_W       = 8;
    localparam int unsigned MAX_SERVERS = 256;
    localparam int unsigned Q_DEPTH     = 4;
    localparam int unsigned Q_AW        = $clog2(Q_DEPTH);
    localparam int unsigned STEP_W      = $clog2(HASH_W);

    localparam logic [SUM_W-1:0]  HASH_TOP = 16'hFFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_SERVERS);

    typedef struct packed {
        logic [7:0] key_byte;
        logic       byte_valid;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  server_index;
        logic              no_server;
        logic [HASH_W-1:0] key_hash;
    } t_out_item;

    // push side of the key queue
    typedef struct packed {
        logic             push;
        logic [SUM_W-1:0] data;
    } t_q_push;

    // pop side of the key queue
    typedef struct packed {
        logic             empty;
        logic [SUM_W-1:0] data;
    } t_q_head;

    // ones' complement 16-bit add with end-around carry
    function automatic logic [SUM_W-1:0] oc_add16(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
    endfunction

endpackage

@@ hdl/khs_front.sv @@
// khs_front: byte-stream accumulator, sums key bytes as little-endian words
// depends on khs_pkg; pushes the inverted folded sum of each key into khs_queue
module khs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  khs_pkg::t_in_item i_item,
    output khs_pkg::t_q_push  o_push
);
    import khs_pkg::*;

    logic [SUM_W-1:0] r_sum, n_sum;
    logic [7:0]       r_held, n_held;
    logic             r_odd, n_odd;
    logic [SUM_W-1:0] add_word;
    logic             do_add;
    logic [SUM_W-1:0] add_res;

    always_comb begin
        add_word = {r_held, 8'h00} >> 8;
        do_add   = 1'b0;
        n_held   = r_held;
        n_odd    = r_odd;
        if (i_item.byte_valid) begin
            if (r_odd) begin
                // completes a pair: this byte is the high half
                add_word = {i_item.key_byte, r_held};
                do_add   = 1'b1;
                n_held   = 8'h00;
                n_odd    = 1'b0;
            end else if (i_item.last_byte) begin
                // lone final byte
                add_word = {8'h00, i_item.key_byte};
                do_add   = 1'b1;
            end else begin
                n_held = i_item.key_byte;
                n_odd  = 1'b1;
            end
        end else if (i_item.last_byte && r_odd) begin
            add_word = {8'h00, r_held};
            do_add   = 1'b1;
        end
        add_res = oc_add16(r_sum, add_word);
        n_sum   = do_add ? add_res : r_sum;
    end

    assign o_push.push = i_accept && i_item.last_byte;
    assign o_push.data = ~n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_held <= '0;
            r_odd  <= 1'b0;
        end else if (i_accept) begin
            if (i_item.last_byte) begin
                r_sum  <= '0;
                r_held <= '0;
                r_odd  <= 1'b0;
            end else begin
                r_sum  <= n_sum;
                r_held <= n_held;
                r_odd  <= n_odd;
            end
        end
    end

endmodule

@@ hdl/khs_queue.sv @@
// khs_queue: short fifo of folded key sums between front and back
// depends on khs_pkg
module khs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  khs_pkg::t_q_push i_push,
    input  logic             i_pop,
    output khs_pkg::t_q_head o_head,
    output logic             o_full
);
    import khs_pkg::*;

    logic [SUM_W-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_fill == (Q_AW+1)'(Q_DEPTH));
    assign o_head.empty = (r_fill == '0);
    assign o_head.data  = r_mem[r_rd_ptr];
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && !o_head.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ hdl/khs_back.sv @@
// khs_back: bit-serial modulo of the 32-bit hash by the server count, output register
// depends on khs_pkg; pops key sums from khs_queue
module khs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [8:0]         i_server_count,
    input  khs_pkg::t_q_head   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output khs_pkg::t_out_item o_out_item
);
    import khs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state              r_state;
    logic [HASH_W-1:0]   r_hash;
    logic [HASH_W-1:0]   r_shift;
    logic [CNT_W-1:0]    r_div;
    logic [CNT_W-1:0]    r_rem;
    logic [STEP_W-1:0]   r_step;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic [CNT_W-1:0]    cnt_clamped;
    logic [CNT_W-1:0]    rem_shl;
    logic [CNT_W-1:0]    n_rem;
    logic                out_free;

    assign cnt_clamped = (i_server_count > CNT_MAX) ? CNT_MAX : i_server_count;
    // one quotient bit per cycle: shift in the next hash bit, subtract if it fits
    assign rem_shl     = {r_rem[CNT_W-2:0], r_shift[HASH_W-1]};
    assign n_rem       = (rem_shl >= r_div) ? rem_shl - r_div : rem_shl;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == ST_IDLE) && !i_head.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hash  <= {HASH_TOP, i_head.data};
            r_shift <= {HASH_TOP, i_head.data};
            r_div   <= cnt_clamped;
            r_rem   <= '0;
        end else if (r_state == ST_RUN) begin
            r_shift <= {r_shift[HASH_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_item.key_hash     <= r_hash;
            r_out_item.no_server    <= (r_div == '0);
            r_out_item.server_index <= (r_div == '0) ? '0 : r_rem[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_head.empty) begin
                        r_step  <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(HASH_W - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/key_hash_server_select.sv @@
// key_hash_server_select: top level, joins front accumulator, key queue and modulo back end
// depends on khs_pkg, khs_front, khs_queue, khs_back
//
// Key bytes stream in one transfer per cycle unless stalled; each pair of bytes
// is added as a little-endian word with end-around carry, and a lone final byte
// as a low byte. The transfer with last_byte set closes the key: its inverted
// folded sum goes into a four-entry queue, and the accumulator is clear for the
// next key in the following cycle. The back end takes one key at a time from the
// queue and reduces the 32-bit hash (upper half all ones) modulo server_count
// with a restoring remainder unit that handles one hash bit per cycle; a key
// passes through a pop, 32 remainder steps and a load of the output register.
// Keys that stream longer than the back end needs per key see no stalls while
// the output is free; a run of short keys is paced by the remainder unit once
// the queue fills. A server_count above 256 acts as 256; a count of zero gives
// no_server with index 0. The user must write server_count through the config
// port only while no key is in flight; the block does not enforce this.
module key_hash_server_select (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [8:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  khs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output khs_pkg::t_out_item o_out_item
);
    import khs_pkg::*;

    // server count register
    logic [CNT_W-1:0] r_server_count;
    // input transfer taken this cycle
    logic             in_accept;
    t_q_push          q_push;
    t_q_head          q_head;
    logic             q_pop;
    logic             q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_server_count <= i_cfg_wr_data;
        end
    end

    // hold off input while the queue has no room for a finished key
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    khs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (q_push)
    );

    khs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full)
    );

    khs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_server_count (r_server_count),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_item     (o_out_item)
    );

endmodule

@@ hdl/khs_checker.sv @@
// khs_checker: port-level assertions for key_hash_server_select, bound to the top level
// depends on khs_pkg
module khs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input khs_pkg::t_out_item o_out_item
);
    import khs_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // no server means index zero
    a_no_server_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.no_server |-> o_out_item.server_index == '0)
        else $error("index not zero with no server");

    // hash upper half is always ones
    a_hash_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.key_hash[31:16] == HASH_TOP)
        else $error("hash upper half not all ones");

endmodule

bind key_hash_server_select khs_checker u_khs_checker (.*);
